// ----- sv/assert_macros.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define SDFE_ASSERT_IMP(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("implication check failed");
`define SDFE_ASSERT_NEXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("next-cycle check failed");
`define SDFE_ASSERT_ALWAYS(lbl, clk, a) \
   lbl: assert property (@(posedge clk) (a)) \
      else $error("invariant check failed");
`else
`define SDFE_ASSERT_IMP(lbl, clk, rst, a, c)
`define SDFE_ASSERT_NEXT(lbl, clk, rst, a, c)
`define SDFE_ASSERT_ALWAYS(lbl, clk, a)
`endif
`endif

// ----- sv/sdfe_pkg.sv -----
// Shared constants, types and mask functions of the snapshot delta encoder.
`default_nettype none
package sdfe_pkg;
   localparam int CONTROL_SLOTS    = 32;
   localparam int GRAPHICS_CARDS   = 64;
   localparam int BACKGROUND_CARDS = 240;
   localparam int SOUND_REGS       = 14;
   localparam int QUEUE_DEPTH      = 4;
   localparam int FRAME_BYTES      = 50;

   localparam logic [31:0] FRAME_HEADER = 32'h2A3A4A5A;
   localparam logic [13:0] MASK_FULL    = 14'h3FFF;
   localparam logic [13:0] MASK_BG_LOW  = 14'h39FF;

   localparam logic [2:0] KIND_CTRL  = 3'd0;
   localparam logic [2:0] KIND_GFX   = 3'd1;
   localparam logic [2:0] KIND_BG    = 3'd2;
   localparam logic [2:0] KIND_SND_A = 3'd3;
   localparam logic [2:0] KIND_SND_B = 3'd4;
   localparam logic [2:0] KIND_FRAME = 3'd5;

   localparam logic [1:0] ENT_ONE   = 2'd0;
   localparam logic [1:0] ENT_TWO   = 2'd1;
   localparam logic [1:0] ENT_EIGHT = 2'd2;
   localparam logic [1:0] ENT_FRAME = 2'd3;

   typedef struct packed {
      logic [1:0]  code;
      logic [63:0] data;
   } entry_type;

   typedef struct packed {
      logic [2*SOUND_REGS-1:0]    snd;
      logic [BACKGROUND_CARDS-1:0] bg;
      logic [GRAPHICS_CARDS-1:0]  gfx;
      logic [CONTROL_SLOTS-1:0]   ctrl;
   } snap_type;

   function automatic logic [13:0] control_mask(input logic [4:0] slot);
      logic [13:0] m;
      if (slot < 5'd8)       m = 14'h07FF;
      else if (slot < 5'd16) m = 14'h0FFF;
      else if (slot < 5'd24) m = 14'h3FFF;
      else if (slot < 5'd29) m = 14'h000F;
      else if (slot < 5'd31) m = 14'h0007;
      else                   m = 14'h0003;
      return m;
   endfunction

   function automatic logic [7:0] sound_mask(input logic [3:0] r);
      logic [7:0] m;
      case (r)
         4'd0, 4'd1, 4'd2, 4'd3, 4'd7: m = 8'hFF;
         4'd4, 4'd5, 4'd6, 4'd10:      m = 8'h0F;
         4'd8, 4'd11, 4'd12, 4'd13:    m = 8'h3F;
         4'd9:                         m = 8'h1F;
         default:                      m = 8'h00;
      endcase
      return m;
   endfunction
endpackage
`default_nettype wire

// ----- sv/sdfe_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sdfe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

// ----- sv/sdfe_front.sv -----
// Front end: accepts requests, compares with stored copies, tracks change bits.
`default_nettype none
module sdfe_front #(
   parameter int QDEPTH = sdfe_pkg::QUEUE_DEPTH
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [2:0]                  req_kind,
   input  wire logic [7:0]                  req_slot_index,
   input  wire logic [63:0]                 req_value,
   input  wire logic                        req_video_enable,
   input  wire logic                        req_display_mode,
   input  wire logic                        req_envelope_retrigger,
   input  wire logic [$clog2(QDEPTH+1)-1:0] q_count,
   input  wire logic                        frame_done,
   output logic                             push,
   output sdfe_pkg::entry_type              entry,
   output sdfe_pkg::snap_type               snapshot
);
   localparam int CW = $clog2(QDEPTH+1);

   logic        accept;
   logic        s2_valid_ff;
   logic [2:0]  s2_kind_ff;
   logic [7:0]  s2_idx_ff;
   logic [63:0] s2_value_ff;
   logic        s2_ven_ff, s2_mode_ff, s2_retrig_ff;
   logic        frame_busy_ff;

   logic [13:0] ctrl_ff [sdfe_pkg::CONTROL_SLOTS];
   logic [7:0]  snd_ff [2*sdfe_pkg::SOUND_REGS];
   logic [sdfe_pkg::GRAPHICS_CARDS-1:0]   gfx_vld_ff;
   logic [sdfe_pkg::BACKGROUND_CARDS-1:0] bg_vld_ff;
   logic [sdfe_pkg::CONTROL_SLOTS-1:0]    ctrl_chg_ff;
   logic [sdfe_pkg::GRAPHICS_CARDS-1:0]   gfx_chg_ff;
   logic [sdfe_pkg::BACKGROUND_CARDS-1:0] bg_chg_ff;
   logic [2*sdfe_pkg::SOUND_REGS-1:0]     snd_chg_ff;
   sdfe_pkg::snap_type snap_ff;

   logic        fwd_gfx_ff, fwd_bg_ff;
   logic [7:0]  fwd_idx_ff;
   logic [63:0] fwd_data_ff;

   logic [63:0] gfx_rdata;
   logic [13:0] bg_rdata;
   logic [63:0] gfx_old;
   logic [13:0] bg_old, bg_v, ctrl_v;
   logic [4:0]  snd_pos;
   logic [7:0]  snd_v;
   logic        ctrl_wr, gfx_we, bg_we, snd_wr, frame_go;

   assign req_stall = (({1'b0, q_count} + {{CW{1'b0}}, s2_valid_ff}) >= (CW+1)'(QDEPTH))
                      || (frame_busy_ff && req_kind == sdfe_pkg::KIND_FRAME);
   assign accept = req_valid && !req_stall;

   sdfe_ram #(.WIDTH(64), .DEPTH(sdfe_pkg::GRAPHICS_CARDS)) u_gfx_ram (
      .clock (clock),
      .we    (gfx_we),
      .waddr (s2_idx_ff[5:0]),
      .wdata (s2_value_ff),
      .raddr (req_slot_index[5:0]),
      .rdata (gfx_rdata)
   );

   sdfe_ram #(.WIDTH(14), .DEPTH(sdfe_pkg::BACKGROUND_CARDS)) u_bg_ram (
      .clock (clock),
      .we    (bg_we),
      .waddr (s2_idx_ff),
      .wdata (bg_v),
      .raddr (req_slot_index),
      .rdata (bg_rdata)
   );

   always_comb begin
      ctrl_v = s2_value_ff[13:0] & sdfe_pkg::control_mask(s2_idx_ff[4:0]);
      if (s2_idx_ff[4:0] == 5'd31) begin
         ctrl_v[3:2] = {s2_mode_ff, s2_ven_ff};
      end
      bg_v = s2_value_ff[13:0] &
             ((s2_value_ff[11] && !s2_mode_ff) ? sdfe_pkg::MASK_BG_LOW : sdfe_pkg::MASK_FULL);
      snd_pos = ((s2_kind_ff == sdfe_pkg::KIND_SND_B) ? 5'd14 : 5'd0) + {1'b0, s2_idx_ff[3:0]};
      snd_v = s2_value_ff[7:0] & sdfe_pkg::sound_mask(s2_idx_ff[3:0]);
      if (fwd_gfx_ff && fwd_idx_ff == s2_idx_ff) gfx_old = fwd_data_ff;
      else if (gfx_vld_ff[s2_idx_ff[5:0]])      gfx_old = gfx_rdata;
      else                                       gfx_old = '0;
      if (fwd_bg_ff && fwd_idx_ff == s2_idx_ff)  bg_old = fwd_data_ff[13:0];
      else if (bg_vld_ff[s2_idx_ff])             bg_old = bg_rdata;
      else                                       bg_old = '0;

      push     = 1'b0;
      entry    = '0;
      ctrl_wr  = 1'b0;
      gfx_we   = 1'b0;
      bg_we    = 1'b0;
      snd_wr   = 1'b0;
      frame_go = 1'b0;
      if (s2_valid_ff) begin
         case (s2_kind_ff)
            sdfe_pkg::KIND_CTRL: begin
               if (s2_idx_ff < 8'(sdfe_pkg::CONTROL_SLOTS)
                   && ctrl_v != ctrl_ff[s2_idx_ff[4:0]]) begin
                  ctrl_wr = 1'b1;
                  push = 1'b1;
                  entry.code = sdfe_pkg::ENT_TWO;
                  entry.data = {50'd0, ctrl_v};
               end
            end
            sdfe_pkg::KIND_GFX: begin
               if (s2_idx_ff < 8'(sdfe_pkg::GRAPHICS_CARDS) && s2_value_ff != gfx_old) begin
                  gfx_we = 1'b1;
                  push = 1'b1;
                  entry.code = sdfe_pkg::ENT_EIGHT;
                  entry.data = s2_value_ff;
               end
            end
            sdfe_pkg::KIND_BG: begin
               if (s2_idx_ff < 8'(sdfe_pkg::BACKGROUND_CARDS) && bg_v != bg_old) begin
                  bg_we = 1'b1;
                  push = 1'b1;
                  entry.code = sdfe_pkg::ENT_TWO;
                  entry.data = {50'd0, bg_v};
               end
            end
            sdfe_pkg::KIND_SND_A, sdfe_pkg::KIND_SND_B: begin
               if (s2_idx_ff < 8'(sdfe_pkg::SOUND_REGS)) begin
                  snd_wr = snd_v != snd_ff[snd_pos];
                  if (snd_wr || (s2_idx_ff == 8'd10 && s2_retrig_ff)) begin
                     push = 1'b1;
                     entry.code = sdfe_pkg::ENT_ONE;
                     entry.data = {56'd0, snd_v};
                  end
               end
            end
            sdfe_pkg::KIND_FRAME: begin
               frame_go = 1'b1;
               push = 1'b1;
               entry.code = sdfe_pkg::ENT_FRAME;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      s2_kind_ff   <= req_kind;
      s2_idx_ff    <= req_slot_index;
      s2_value_ff  <= req_value;
      s2_ven_ff    <= req_video_enable;
      s2_mode_ff   <= req_display_mode;
      s2_retrig_ff <= req_envelope_retrigger;
      fwd_idx_ff   <= s2_idx_ff;
      fwd_data_ff  <= gfx_we ? s2_value_ff : {50'd0, bg_v};
      if (frame_go) begin
         snap_ff <= '{snd: snd_chg_ff, bg: bg_chg_ff, gfx: gfx_chg_ff, ctrl: ctrl_chg_ff};
      end
      if (reset) begin
         s2_valid_ff   <= 1'b0;
         frame_busy_ff <= 1'b0;
         fwd_gfx_ff    <= 1'b0;
         fwd_bg_ff     <= 1'b0;
         gfx_vld_ff    <= '0;
         bg_vld_ff     <= '0;
         ctrl_chg_ff   <= '0;
         gfx_chg_ff    <= '0;
         bg_chg_ff     <= '0;
         snd_chg_ff    <= '0;
         for (int i = 0; i < sdfe_pkg::CONTROL_SLOTS; i++) ctrl_ff[i] <= '0;
         for (int i = 0; i < 2*sdfe_pkg::SOUND_REGS; i++) snd_ff[i] <= '0;
      end else begin
         s2_valid_ff <= accept;
         fwd_gfx_ff  <= gfx_we;
         fwd_bg_ff   <= bg_we;
         if (accept && req_kind == sdfe_pkg::KIND_FRAME) frame_busy_ff <= 1'b1;
         else if (frame_done)                            frame_busy_ff <= 1'b0;
         if (ctrl_wr) begin
            ctrl_ff[s2_idx_ff[4:0]]     <= ctrl_v;
            ctrl_chg_ff[s2_idx_ff[4:0]] <= 1'b1;
         end
         if (gfx_we) begin
            gfx_vld_ff[s2_idx_ff[5:0]] <= 1'b1;
            gfx_chg_ff[s2_idx_ff[5:0]] <= 1'b1;
         end
         if (bg_we) begin
            bg_vld_ff[s2_idx_ff] <= 1'b1;
            bg_chg_ff[s2_idx_ff] <= 1'b1;
         end
         if (snd_wr) snd_ff[snd_pos] <= snd_v;
         if (push && entry.code == sdfe_pkg::ENT_ONE) snd_chg_ff[snd_pos] <= 1'b1;
         if (frame_go) begin
            ctrl_chg_ff <= '0;
            gfx_chg_ff  <= '0;
            bg_chg_ff   <= '0;
            snd_chg_ff  <= '0;
         end
      end
   end

   assign snapshot = snap_ff;
endmodule
`default_nettype wire

// ----- sv/sdfe_queue.sv -----
// Small FIFO of pending emit requests between front and back end.
`default_nettype none
module sdfe_queue #(
   parameter int QDEPTH = sdfe_pkg::QUEUE_DEPTH
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        push,
   input  wire sdfe_pkg::entry_type         din,
   input  wire logic                        pop,
   output sdfe_pkg::entry_type              head,
   output logic                             empty,
   output logic [$clog2(QDEPTH+1)-1:0]      count
);
   localparam int AW = $clog2(QDEPTH);

   sdfe_pkg::entry_type mem_ff [QDEPTH];
   logic [AW-1:0] wp_ff, rp_ff;
   logic [$clog2(QDEPTH+1)-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= din;
      if (reset) begin
         wp_ff    <= '0;
         rp_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) wp_ff <= (wp_ff == AW'(QDEPTH-1)) ? '0 : wp_ff + 1'b1;
         if (pop)  rp_ff <= (rp_ff == AW'(QDEPTH-1)) ? '0 : rp_ff + 1'b1;
         if (push && !pop)      count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
   end

   assign head  = mem_ff[rp_ff];
   assign empty = (count_ff == '0);
   assign count = count_ff;
endmodule
`default_nettype wire

// ----- sv/sdfe_back.sv -----
// Back end: serializes queued requests into bytes through the output register.
`default_nettype none
module sdfe_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire sdfe_pkg::entry_type head,
   input  wire logic                empty,
   input  wire sdfe_pkg::snap_type  snapshot,
   output logic                     pop,
   output logic                     frame_done,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [7:0]               rsp_out_byte,
   output logic                     rsp_run_last,
   output logic                     rsp_frame_last
);
   logic [5:0]   idx_ff;
   logic         valid_ff, run_last_ff, frame_last_ff;
   logic [7:0]   byte_ff;
   logic [5:0]   last_idx;
   logic [399:0] fvec;
   logic [7:0]   cur_byte;
   logic         load, is_last, is_frame;

   always_comb begin
      fvec = {2'b00, snapshot.snd[27:14], 2'b00, snapshot.snd[13:0],
              snapshot.bg, snapshot.gfx, snapshot.ctrl, sdfe_pkg::FRAME_HEADER};
      is_frame = head.code == sdfe_pkg::ENT_FRAME;
      case (head.code)
         sdfe_pkg::ENT_ONE:   last_idx = 6'd0;
         sdfe_pkg::ENT_TWO:   last_idx = 6'd1;
         sdfe_pkg::ENT_EIGHT: last_idx = 6'd7;
         default:             last_idx = 6'(sdfe_pkg::FRAME_BYTES - 1);
      endcase
      cur_byte = is_frame ? fvec[{idx_ff, 3'b000} +: 8] : head.data[{idx_ff[2:0], 3'b000} +: 8];
      load    = !empty && (!valid_ff || !rsp_stall);
      is_last = idx_ff == last_idx;
   end

   assign pop        = load && is_last;
   assign frame_done = load && is_last && is_frame;

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff       <= cur_byte;
         run_last_ff   <= is_last;
         frame_last_ff <= is_last && is_frame;
      end
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         if (load)           valid_ff <= 1'b1;
         else if (!rsp_stall) valid_ff <= 1'b0;
         if (load) idx_ff <= is_last ? 6'd0 : idx_ff + 6'd1;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_run_last   = run_last_ff;
   assign rsp_frame_last = frame_last_ff;
endmodule
`default_nettype wire

// ----- sv/snapshot_delta_frame_encoder.sv -----
// Top level of the snapshot delta frame encoder.
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/stall    | kind, slot_index, value, enables, retrigger
//  rsp     | out       | rsp_valid/stall    | out_byte, run_last, frame_last
//
// One request enters per cycle while req_stall is low; its compare happens the next cycle.
// Output runs at one byte per cycle while rsp_stall is low: 1, 2 or 8 bytes per changed element and
// 50 bytes per frame end, so the byte serializer sets the sustained rate.
// Reset clears all stored copies and change bits at once (valid bits on the RAMs).
// A second frame end waits until the previous frame record's last byte is loaded into the output register.
`default_nettype none
`include "assert_macros.svh"
module snapshot_delta_frame_encoder #(
   parameter int QDEPTH = sdfe_pkg::QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_kind,
   input  wire logic [7:0]  req_slot_index,
   input  wire logic [63:0] req_value,
   input  wire logic        req_video_enable,
   input  wire logic        req_display_mode,
   input  wire logic        req_envelope_retrigger,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_run_last,
   output logic             rsp_frame_last
);
   logic                          push, pop, empty, frame_done;
   sdfe_pkg::entry_type           entry, head;
   sdfe_pkg::snap_type            snapshot;
   logic [$clog2(QDEPTH+1)-1:0]   q_count;

   sdfe_front #(.QDEPTH(QDEPTH)) u_front (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_kind               (req_kind),
      .req_slot_index         (req_slot_index),
      .req_value              (req_value),
      .req_video_enable       (req_video_enable),
      .req_display_mode       (req_display_mode),
      .req_envelope_retrigger (req_envelope_retrigger),
      .q_count                (q_count),
      .frame_done             (frame_done),
      .push                   (push),
      .entry                  (entry),
      .snapshot               (snapshot)
   );

   sdfe_queue #(.QDEPTH(QDEPTH)) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .din   (entry),
      .pop   (pop),
      .head  (head),
      .empty (empty),
      .count (q_count)
   );

   sdfe_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .empty          (empty),
      .snapshot       (snapshot),
      .pop            (pop),
      .frame_done     (frame_done),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_run_last   (rsp_run_last),
      .rsp_frame_last (rsp_frame_last)
   );

   `SDFE_ASSERT_IMP(a_no_overflow, clock, reset, push && !pop, q_count < ($clog2(QDEPTH+1))'(QDEPTH))
   `SDFE_ASSERT_IMP(a_no_underflow, clock, reset, pop, !empty)
   `SDFE_ASSERT_IMP(a_frame_ends_run, clock, reset, rsp_valid && rsp_frame_last, rsp_run_last)
   `SDFE_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid && q_count == '0)
endmodule
`default_nettype wire
